@@ design/slpp_pkg.sv @@
// ----------------------------------------------------------------------------
// slpp_pkg: shared types and constants for the lowest spectral peak block
// Configuration register indexes, the configuration and result bundles and
// the bin to pitch class mapping used at the end of each frame.
// ----------------------------------------------------------------------------
`default_nettype none

package slpp_pkg;

	// default number of bins in one frame
	localparam int FRAME_BINS_DEFAULT = 512;

	// field widths
	localparam int MAG_W   = 16;
	localparam int LEVEL_W = 10;
	localparam int BIN_W   = 9;
	localparam int PITCH_W = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FLOOR      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_BIN         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BIN        = 2'd3;

	// configuration reset values
	localparam logic [LEVEL_W-1:0] LEVEL_THRESHOLD_RST = 10'd600;
	localparam logic [MAG_W-1:0]   PEAK_FLOOR_RST      = 16'd164;
	localparam logic [BIN_W-1:0]   LOW_BIN_RST         = 9'd1;
	localparam logic [BIN_W-1:0]   HIGH_BIN_RST        = 9'd116;

	// number of semitones in an octave
	localparam logic [PITCH_W-1:0] SEMITONES = 4'd12;
	// pitch class of the lowest semitone edge inside the normalized octave
	localparam logic [PITCH_W-1:0] PITCH_OFFSET = 4'd5;

	// semitone edges of bins normalized into the octave 256..511
	localparam logic [BIN_W-1:0] SEMITONE_EDGE [12] = '{
		9'd268, 9'd283, 9'd300, 9'd318, 9'd337, 9'd357,
		9'd378, 9'd401, 9'd424, 9'd450, 9'd476, 9'd505
	};

	typedef struct packed {
		logic [LEVEL_W-1:0] level_threshold;
		logic [MAG_W-1:0]   peak_floor;
		logic [BIN_W-1:0]   low_bin;
		logic [BIN_W-1:0]   high_bin;
	} slpp_cfg_t;

	typedef struct packed {
		logic               note_found;
		logic [BIN_W-1:0]   peak_bin;
		logic [PITCH_W-1:0] pitch_class;
	} slpp_result_t;

	// pitch class of a bin: normalize into one octave, count edges passed
	function automatic logic [PITCH_W-1:0] pitch_of_bin(input logic [BIN_W-1:0] b);
		logic [BIN_W-1:0]   v;
		logic [PITCH_W-1:0] m;
		logic [PITCH_W:0]   s;
		v = b;
		m = '0;
		for (int k = 0; k < BIN_W - 1; k++) begin
			if (v[BIN_W-1] == 1'b0) begin
				v = {v[BIN_W-2:0], 1'b0};
			end
		end
		for (int i = 0; i < 12; i++) begin
			if (v >= SEMITONE_EDGE[i]) begin
				m = m + 4'd1;
			end
		end
		s = {1'b0, m} + {1'b0, PITCH_OFFSET};
		if (s >= {1'b0, SEMITONES}) begin
			s = s - {1'b0, SEMITONES};
		end
		if (b == '0) begin
			s = '0;
		end
		return s[PITCH_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ design/slpp_cfg.sv @@
// ----------------------------------------------------------------------------
// slpp_cfg: configuration registers
// Holds level threshold, peak floor and the accepted bin range; writes are
// registered and the port never stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module slpp_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [slpp_pkg::CFG_IDX_W-1:0]      wr_index,
	input  wire logic [slpp_pkg::CFG_DATA_W-1:0]     wr_data,
	output      slpp_pkg::slpp_cfg_t                 cfg
);

	slpp_pkg::slpp_cfg_t cfg_q;

	// register write decoder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_threshold <= slpp_pkg::LEVEL_THRESHOLD_RST;
			cfg_q.peak_floor      <= slpp_pkg::PEAK_FLOOR_RST;
			cfg_q.low_bin         <= slpp_pkg::LOW_BIN_RST;
			cfg_q.high_bin        <= slpp_pkg::HIGH_BIN_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				slpp_pkg::CFG_LEVEL_THRESHOLD: begin
					cfg_q.level_threshold <= wr_data[slpp_pkg::LEVEL_W-1:0];
				end
				slpp_pkg::CFG_PEAK_FLOOR: begin
					cfg_q.peak_floor <= wr_data[slpp_pkg::MAG_W-1:0];
				end
				slpp_pkg::CFG_LOW_BIN: begin
					cfg_q.low_bin <= wr_data[slpp_pkg::BIN_W-1:0];
				end
				slpp_pkg::CFG_HIGH_BIN: begin
					cfg_q.high_bin <= wr_data[slpp_pkg::BIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ design/slpp_peak.sv @@
// ----------------------------------------------------------------------------
// slpp_peak: per-bin peak tracker
// Keeps the bin count, the two previous magnitudes and the latched lowest
// peak; forms the frame result when the last bin is processed.
// ----------------------------------------------------------------------------
`default_nettype none

module slpp_peak #(
	parameter int FRAME_BINS = slpp_pkg::FRAME_BINS_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              step,
	input  wire logic [slpp_pkg::MAG_W-1:0]        magnitude,
	input  wire logic [slpp_pkg::LEVEL_W-1:0]      mic_level,
	input  wire logic                              frame_end,
	input  wire slpp_pkg::slpp_cfg_t               cfg,
	output      slpp_pkg::slpp_result_t            result
);

	localparam int CW   = $clog2(FRAME_BINS + 1);
	localparam int CMPW = (CW > slpp_pkg::BIN_W) ? CW : slpp_pkg::BIN_W;

	logic [CW-1:0]                   bin_cnt_q;
	logic [slpp_pkg::MAG_W-1:0]      prev_q;
	logic [slpp_pkg::MAG_W-1:0]      prev_prev_q;
	logic                            loud_q;
	logic                            latched_q;
	logic [slpp_pkg::BIN_W-1:0]      lbin_q;

	logic                            first_bin;
	logic                            in_frame;
	logic                            loud_d;
	logic                            latched_cur;
	logic [slpp_pkg::BIN_W-1:0]      lbin_cur;
	logic [CW-1:0]                   cand;
	logic [CMPW-1:0]                 cand_x;
	logic                            hit;
	logic                            latched_d;
	logic [slpp_pkg::BIN_W-1:0]      lbin_d;
	logic                            found;
	logic [slpp_pkg::BIN_W-1:0]      out_bin;

	// frame start reloads the loudness and the latch
	assign first_bin   = (bin_cnt_q == '0);
	assign in_frame    = (bin_cnt_q < CW'(FRAME_BINS));
	assign loud_d      = first_bin ? (mic_level > cfg.level_threshold) : loud_q;
	assign latched_cur = first_bin ? 1'b0 : latched_q;
	assign lbin_cur    = first_bin ? '0 : lbin_q;

	// three-tap test on the previous bin
	assign cand   = bin_cnt_q - CW'(1);
	assign cand_x = CMPW'(cand);
	assign hit    = in_frame && (bin_cnt_q >= CW'(2)) && !latched_cur
		&& (cand_x >= CMPW'(cfg.low_bin)) && (cand_x <= CMPW'(cfg.high_bin))
		&& (prev_q > prev_prev_q) && (prev_q > magnitude) && (prev_q > cfg.peak_floor);

	assign latched_d = latched_cur | hit;
	assign lbin_d    = hit ? cand_x[slpp_pkg::BIN_W-1:0] : lbin_cur;

	// frame result
	assign found   = loud_d && latched_d;
	assign out_bin = found ? lbin_d : '0;

	always_comb begin
		result.note_found  = found;
		result.peak_bin    = out_bin;
		result.pitch_class = found ? slpp_pkg::pitch_of_bin(out_bin) : '0;
	end

	// tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_cnt_q   <= '0;
			prev_q      <= '0;
			prev_prev_q <= '0;
			loud_q      <= 1'b0;
			latched_q   <= 1'b0;
			lbin_q      <= '0;
		end else if (step) begin
			loud_q    <= loud_d;
			latched_q <= latched_d;
			lbin_q    <= lbin_d;
			if (in_frame) begin
				prev_prev_q <= prev_q;
				prev_q      <= magnitude;
			end
			if (frame_end) begin
				bin_cnt_q <= '0;
			end else if (in_frame) begin
				bin_cnt_q <= bin_cnt_q + CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ design/spectral_lowest_peak_pitch_class_core.sv @@
// ----------------------------------------------------------------------------
// spectral_lowest_peak_pitch_class_core: lowest spectral peak and pitch class
// Streams one FFT magnitude frame per call, one bin per transaction, and
// reports the lowest qualifying local maximum with its pitch class.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one bin per transaction,
//   bin 0 first; mic_level is sampled on the first bin, frame_end marks the
//   last bin. Output channel (out_valid / out_stall) carries one transaction
//   per frame: note_found, peak_bin and pitch_class.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) is
//   always ready; write it only while no frame is in flight.
// Timing:
//   A bin is taken into the input register, passed to the peak tracker
//   once the output register is free, and the frame result sits in the
//   output register: out_valid rises when the last bin leaves the tracker.
//   One bin per cycle is sustained unless a held result is stalled; the
//   input register and the output register decouple the two channels.
// Reset and stalls:
//   arst_n clears the tracker, both pipeline registers and restores the
//   default configuration. While out_stall holds a result, one more bin may
//   be taken into the input register, then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module spectral_lowest_peak_pitch_class_core #(
	parameter int FRAME_BINS = slpp_pkg::FRAME_BINS_DEFAULT
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output      logic                                in_stall,
	input  wire logic [slpp_pkg::MAG_W-1:0]          magnitude,
	input  wire logic [slpp_pkg::LEVEL_W-1:0]        mic_level,
	input  wire logic                                frame_end,
	output      logic                                out_valid,
	input  wire logic                                out_stall,
	output      logic                                note_found,
	output      logic [slpp_pkg::BIN_W-1:0]          peak_bin,
	output      logic [slpp_pkg::PITCH_W-1:0]        pitch_class,
	input  wire logic                                cfg_valid,
	output      logic                                cfg_ready,
	input  wire logic [slpp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [slpp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	slpp_pkg::slpp_cfg_t     cfg;
	slpp_pkg::slpp_result_t  result;

	logic                            s1_valid_q;
	logic [slpp_pkg::MAG_W-1:0]      mag_s1;
	logic [slpp_pkg::LEVEL_W-1:0]    level_s1;
	logic                            last_s1;
	logic                            out_valid_q;
	slpp_pkg::slpp_result_t          result_q;
	logic                            out_free;
	logic                            advance;
	logic                            in_take;

	// configuration registers
	assign cfg_ready = 1'b1;

	slpp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// handshake control
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = s1_valid_q && out_free;
	assign in_stall = s1_valid_q && !advance;
	assign in_take  = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_take) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mag_s1   <= magnitude;
			level_s1 <= mic_level;
			last_s1  <= frame_end;
		end
	end

	// peak tracker
	slpp_peak #(
		.FRAME_BINS (FRAME_BINS)
	) u_peak (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.magnitude (mag_s1),
		.mic_level (level_s1),
		.frame_end (last_s1),
		.cfg       (cfg),
		.result    (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign note_found  = result_q.note_found;
	assign peak_bin    = result_q.peak_bin;
	assign pitch_class = result_q.pitch_class;

	// checks on the pipeline and the result encoding
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q)
		else $error("input stalled with empty input register");

	a_no_note_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !note_found) |-> (peak_bin == '0 && pitch_class == '0))
		else $error("result without note carries nonzero bin or pitch");

	a_pitch_in_octave: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_class < slpp_pkg::SEMITONES))
		else $error("pitch class out of range");

	a_bin_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && note_found) |->
			(peak_bin >= cfg.low_bin && peak_bin <= cfg.high_bin))
		else $error("reported peak outside configured bin range");

	a_result_loads_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |-> out_free)
		else $error("result overwrites an unaccepted result");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the lowest spectral peak pitch class core
// Streams magnitude frames through the block under several register settings,
// predicts each frame result (found flag, lowest peak bin, pitch class) from
// the accepted bins, and compares every result transaction field by field.
// Both channels idle and stall at random; one long output hold fills the block.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int FRAME_BINS    = 512;
	localparam int OCTAVE_BASE   = 256;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int LIMIT_CYCLES  = 600000;
	localparam int RANDOM_BINS   = 1500;
	localparam int RANDOM_FRAMES = 48;
	localparam int PHASE_BINS    = 250;
	localparam int MAX_LEN       = 541;

	typedef struct packed {
		logic [slpp_pkg::MAG_W-1:0]   mag;
		logic [slpp_pkg::LEVEL_W-1:0] level;
		logic                         last;
	} bin_item_t;

	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	// block ports
	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [slpp_pkg::MAG_W-1:0]      magnitude = '0;
	logic [slpp_pkg::LEVEL_W-1:0]    mic_level = '0;
	logic                            frame_end = 1'b0;
	logic                            out_valid;
	logic                            out_stall = 1'b1;
	logic                            note_found;
	logic [slpp_pkg::BIN_W-1:0]      peak_bin;
	logic [slpp_pkg::PITCH_W-1:0]    pitch_class;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [slpp_pkg::CFG_IDX_W-1:0]  cfg_index = slpp_pkg::CFG_LEVEL_THRESHOLD;
	logic [slpp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// stimulus and expectations
	bin_item_t              pending_bins[$];
	slpp_pkg::slpp_result_t expected_notes[$];
	int                     bins_queued = 0;
	int                     bins_accepted = 0;
	int                     mismatches = 0;
	int                     cycle_count = 0;

	// predictor copy of the settings and of the peak tracker
	slpp_pkg::slpp_cfg_t        live_cfg;
	int                         bin_count = 0;
	logic [slpp_pkg::MAG_W-1:0] last_mag = '0;
	logic [slpp_pkg::MAG_W-1:0] older_mag = '0;
	logic                       frame_loud = 1'b0;
	logic                       have_peak = 1'b0;
	logic [slpp_pkg::BIN_W-1:0] held_bin = '0;

	// sender burst state
	bin_item_t on_bus;
	int        gap_left = 0;
	int        burst_left = 0;

	// receiver stall state
	rx_mode_t rx_mode = RX_FREE;
	int       rx_cycle = 0;
	int       hold_left = 0;
	logic     hold_arm = 1'b0;
	logic     hold_done = 1'b0;

	always #5 clk = ~clk;

	spectral_lowest_peak_pitch_class_core #(.FRAME_BINS(FRAME_BINS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.magnitude(magnitude),
		.mic_level(mic_level),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.note_found(note_found),
		.peak_bin(peak_bin),
		.pitch_class(pitch_class),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	task automatic report_mismatch(input string what);
		$display("tb_top: mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// pitch class: fold the bin into the octave 256..511, count semitone edges passed
	function automatic logic [slpp_pkg::PITCH_W-1:0] note_of_bin(
		input logic [slpp_pkg::BIN_W-1:0] b);
		int v;
		int steps;
		if (b == '0) return '0;
		v = b;
		steps = 0;
		while (v < OCTAVE_BASE) v = v * 2;
		for (int k = 0; k < 12; k++)
			if (v >= slpp_pkg::SEMITONE_EDGE[k]) steps++;
		return slpp_pkg::PITCH_W'((steps + slpp_pkg::PITCH_OFFSET) % slpp_pkg::SEMITONES);
	endfunction

	// peak tracker: test bin j-1 when bin j arrives, latch the lowest hit
	task automatic track_bin(input bin_item_t it);
		slpp_pkg::slpp_result_t r;
		int cand;
		if (bin_count == 0) begin
			frame_loud = it.level > live_cfg.level_threshold;
			have_peak = 1'b0;
			held_bin = '0;
		end
		if (bin_count < FRAME_BINS) begin
			if (bin_count >= 2 && !have_peak) begin
				cand = bin_count - 1;
				if (cand >= live_cfg.low_bin && cand <= live_cfg.high_bin &&
				    last_mag > older_mag && last_mag > it.mag &&
				    last_mag > live_cfg.peak_floor) begin
					have_peak = 1'b1;
					held_bin = cand[slpp_pkg::BIN_W-1:0];
				end
			end
			older_mag = last_mag;
			last_mag = it.mag;
		end
		if (!it.last) begin
			if (bin_count < FRAME_BINS) bin_count++;
		end else begin
			bin_count = 0;
			r.note_found = frame_loud && have_peak;
			r.peak_bin = r.note_found ? held_bin : '0;
			r.pitch_class = r.note_found ? note_of_bin(held_bin) : '0;
			expected_notes.push_back(r);
		end
	endtask

	task automatic push_bin(input int mag, input int level, input bit last);
		bin_item_t it;
		it.mag = slpp_pkg::MAG_W'(mag);
		it.level = slpp_pkg::LEVEL_W'(level);
		it.last = last;
		pending_bins.push_back(it);
		bins_queued++;
	endtask

	// one register transaction, valid left high for the next one
	task automatic cfg_put(input logic [slpp_pkg::CFG_IDX_W-1:0] idx,
		input logic [slpp_pkg::CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic write_settings(input slpp_pkg::slpp_cfg_t c);
		cfg_put(slpp_pkg::CFG_LEVEL_THRESHOLD, c.level_threshold);
		cfg_put(slpp_pkg::CFG_PEAK_FLOOR, c.peak_floor);
		cfg_put(slpp_pkg::CFG_LOW_BIN, c.low_bin);
		cfg_put(slpp_pkg::CFG_HIGH_BIN, c.high_bin);
		cfg_valid <= 1'b0;
		live_cfg = c;
	endtask

	function automatic slpp_pkg::slpp_cfg_t make_settings(input int thr, input int flr,
		input int lo, input int hi);
		slpp_pkg::slpp_cfg_t c;
		c.level_threshold = slpp_pkg::LEVEL_W'(thr);
		c.peak_floor = slpp_pkg::MAG_W'(flr);
		c.low_bin = slpp_pkg::BIN_W'(lo);
		c.high_bin = slpp_pkg::BIN_W'(hi);
		return c;
	endfunction

	// wait until every queued bin is taken and every result has come back
	task automatic wait_idle();
		while (bins_accepted != bins_queued || expected_notes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// one frame: quiet background at or under the floor with planted peaks, or noise
	task automatic queue_random_frame(input bit force_long, output int len);
		logic [slpp_pkg::MAG_W-1:0] mag [0:MAX_LEN-1];
		int kind, lo, hi, floor_mag, level, plants, pos, win_lo, win_hi, variant;
		bit noise;
		kind = $urandom_range(0, 99);
		lo = live_cfg.low_bin;
		hi = live_cfg.high_bin;
		floor_mag = live_cfg.peak_floor;
		if (force_long || kind < 2) len = $urandom_range(500, MAX_LEN - 1);
		else if (kind < 7) len = $urandom_range(1, 2);
		else if (lo <= hi && hi < 60) len = $urandom_range(lo + 2, hi + 4);
		else len = $urandom_range(3, 48);
		if ($urandom_range(0, 4) != 0 && live_cfg.level_threshold != 10'd1023)
			level = $urandom_range(int'(live_cfg.level_threshold) + 1, 1023);
		else
			level = $urandom_range(0, 1023);
		noise = ($urandom_range(0, 9) == 0);
		for (int b = 0; b < len; b++)
			mag[b] = noise ? slpp_pkg::MAG_W'($urandom)
				: slpp_pkg::MAG_W'($urandom_range(0, floor_mag));
		if (len >= 500 && $urandom_range(0, 1) == 0) begin
			// clean frame with one peak near or past the frame size
			for (int b = 0; b < len; b++) mag[b] = '0;
			pos = $urandom_range(len - 12, len - 1);
			mag[pos] = (floor_mag < 65535)
				? slpp_pkg::MAG_W'($urandom_range(floor_mag + 1, 65535))
				: slpp_pkg::MAG_W'(65535);
		end else if (len >= 3) begin
			plants = $urandom_range(0, 3);
			for (int p = 0; p < plants; p++) begin
				win_lo = (lo < 1) ? 1 : lo;
				win_hi = (hi < len - 2) ? hi : len - 2;
				pos = (win_lo <= win_hi) ? $urandom_range(win_lo, win_hi)
					: $urandom_range(1, len - 2);
				variant = $urandom_range(0, 5);
				if (variant == 0 || floor_mag == 65535)
					mag[pos] = slpp_pkg::MAG_W'(floor_mag);
				else
					mag[pos] = slpp_pkg::MAG_W'($urandom_range(floor_mag + 1, 65535));
				// plateau: equal neighbor is not a strict maximum
				if (variant == 1) mag[pos + 1] = mag[pos];
			end
		end
		for (int b = 0; b < len; b++)
			push_bin(mag[b], (b == 0) ? level : $urandom_range(0, 1023), b == len - 1);
	endtask

	// sender: bursts of random length with random gaps, payload held while stalled
	always @(posedge clk) begin : sender
		bit accepted;
		accepted = in_valid && !in_stall;
		if (accepted) begin
			track_bin(on_bus);
			bins_accepted++;
		end
		if (!in_valid || accepted) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_bins.size() != 0) begin
				on_bus = pending_bins.pop_front();
				magnitude <= on_bus.mag;
				mic_level <= on_bus.level;
				frame_end <= on_bus.last;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, with one long hold once armed
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_arm && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			if (rx_cycle % 48 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_FREE: out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= rx_cycle[2];
			endcase
		end
	end

	// monitor: compare each result transaction with the oldest expectation
	always @(posedge clk) begin : monitor
		slpp_pkg::slpp_result_t want;
		if (out_valid && !out_stall) begin
			if (expected_notes.size() == 0) begin
				report_mismatch($sformatf("unexpected result found=%0d bin=%0d class=%0d",
					note_found, peak_bin, pitch_class));
			end else begin
				want = expected_notes.pop_front();
				if (note_found !== want.note_found)
					report_mismatch($sformatf("note_found %0d, want %0d",
						note_found, want.note_found));
				if (peak_bin !== want.peak_bin)
					report_mismatch($sformatf("peak_bin %0d, want %0d", peak_bin, want.peak_bin));
				if (pitch_class !== want.pitch_class)
					report_mismatch($sformatf("pitch_class %0d, want %0d",
						pitch_class, want.pitch_class));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		slpp_pkg::slpp_cfg_t phase_cfg;
		int random_bins, random_frames, phase_bins, len, drain, phase;
		live_cfg = make_settings(slpp_pkg::LEVEL_THRESHOLD_RST, slpp_pkg::PEAK_FLOOR_RST,
			slpp_pkg::LOW_BIN_RST, slpp_pkg::HIGH_BIN_RST);
		random_bins = 0;
		random_frames = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one and two bin frames, just loud, just quiet, plateau, floor
		push_bin(65535, 1023, 1);
		push_bin(0, 1023, 0);
		push_bin(65535, 0, 1);
		push_bin(0, 601, 0);
		push_bin(200, 0, 0);
		push_bin(100, 1023, 0);
		push_bin(300, 0, 0);
		push_bin(0, 0, 1);
		push_bin(0, 600, 0);
		push_bin(65535, 0, 0);
		push_bin(0, 0, 0);
		push_bin(0, 0, 1);
		push_bin(0, 1023, 0);
		push_bin(500, 0, 0);
		push_bin(500, 0, 0);
		push_bin(0, 0, 0);
		push_bin(164, 0, 0);
		push_bin(0, 0, 0);
		push_bin(165, 0, 0);
		push_bin(0, 0, 1);
		wait_idle();

		// lowest threshold and floor, single bin range
		write_settings(make_settings(0, 0, 1, 1));
		push_bin(0, 1, 0);
		push_bin(1, 0, 0);
		push_bin(0, 0, 1);
		push_bin(0, 0, 0);
		push_bin(1, 0, 0);
		push_bin(0, 0, 1);
		wait_idle();

		// highest threshold and floor, widest range
		write_settings(make_settings(1023, 65535, 1, 510));
		push_bin(0, 1023, 0);
		push_bin(65535, 0, 0);
		push_bin(0, 0, 1);
		wait_idle();

		// inverted range accepts nothing
		write_settings(make_settings(0, 0, 510, 1));
		push_bin(0, 1023, 0);
		push_bin(9, 0, 0);
		push_bin(0, 0, 1);
		wait_idle();

		// random phases, the first one at the top of the bin range opening with a long frame
		phase = 0;
		while (random_bins < RANDOM_BINS || random_frames < RANDOM_FRAMES) begin
			if (phase == 0)
				phase_cfg = make_settings($urandom_range(0, 200), $urandom_range(0, 500),
					$urandom_range(495, 510), 510);
			else if (phase % 5 == 4)
				phase_cfg = make_settings($urandom_range(0, 1023), $urandom_range(0, 2000),
					1, 510);
			else if ($urandom_range(0, 7) == 0)
				phase_cfg = make_settings($urandom_range(0, 1023), $urandom,
					$urandom_range(20, 510), $urandom_range(1, 19));
			else begin
				phase_cfg = make_settings($urandom_range(0, 1023),
					($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000), 0, 0);
				phase_cfg.low_bin = slpp_pkg::BIN_W'($urandom_range(1, 24));
				phase_cfg.high_bin = phase_cfg.low_bin
					+ slpp_pkg::BIN_W'($urandom_range(0, 40));
			end
			wait_idle();
			write_settings(phase_cfg);
			phase_bins = 0;
			while (phase_bins < PHASE_BINS) begin
				queue_random_frame(phase == 0 && phase_bins == 0, len);
				phase_bins += len;
				random_bins += len;
				random_frames++;
			end
			if (phase == 1) hold_arm <= 1'b1;
			phase++;
		end

		// drain and finish
		drain = 0;
		while ((bins_accepted != bins_queued || expected_notes.size() != 0) &&
		       drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		if (bins_accepted != bins_queued)
			report_mismatch($sformatf("%0d bins never taken", bins_queued - bins_accepted));
		if (expected_notes.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_notes.size()));
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

@@ files.f @@
design/slpp_pkg.sv
design/slpp_cfg.sv
design/slpp_peak.sv
design/spectral_lowest_peak_pitch_class_core.sv
tb/tb_top.sv
